// ===== design/rws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roulette wheel selector package
// Shared item types, result codes and arithmetic widths used by the
// sequencer, the shared add/subtract unit and the top level.
// ----------------------------------------------------------------------------
package rws_pkg;

    // Fixed field widths
    localparam int REQ_W   = 1;
    localparam int IDX_W   = 8;
    localparam int FIT_W   = 16;
    localparam int RND_W   = 32;
    localparam int SEL_W   = 8;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 24;
    localparam int CFG_W   = 9;

    // Shared unit is one bit wider than the total so the shifted remainder fits.
    localparam int ALU_W  = TOTAL_W + 1;
    localparam int STEP_W = $clog2(RND_W);

    localparam logic [CFG_W-1:0]  ENTRIES_RESET = 9'd256;
    localparam logic [STEP_W-1:0] STEP_LAST     = 5'd31;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE  = 1'b0;
    localparam logic [REQ_W-1:0] REQ_SELECT = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ZERO_TOTAL = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RAN_OFF    = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [IDX_W-1:0] entry_index;
        logic [FIT_W-1:0] fitness_value;
        logic [RND_W-1:0] random_word;
    } in_item_t;

    typedef struct packed {
        logic [SEL_W-1:0]   selected_index;
        logic [STAT_W-1:0]  status;
        logic [TOTAL_W-1:0] fitness_sum;
    } out_item_t;

    // Operation presented to the shared add/subtract unit
    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    // Result of the shared unit; carry set on a subtract means a >= b
    typedef struct packed {
        logic             carry;
        logic [ALU_W-1:0] sum;
    } alu_rsp_t;

endpackage
`default_nettype wire

// ===== design/roulette_wheel_selector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roulette wheel selector core
// Fitness-proportional selection over a table of 16-bit fitness values.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry requests. A write stores one fitness
//   entry; a select sums the entries in use, reduces random_word modulo the
//   total and returns the first entry whose running sum exceeds it.
//   out_valid/out_ready/out_data return exactly one result per request.
//   cfg_valid/cfg_ready/cfg_data write entries_in_use (reset value 256), always
//   ready; the user must write it only while idle, as the block does not check.
// Sequence:
//   A write's result passes through the finish state and the output register.
//   A select runs in order: sum the entries in use, test the total, the
//   bit-serial remainder, the walk, and then the result and output
//   registers, all on the single adder and the one memory read port. One
//   request is in flight at a time.
// Reset:
//   After reset the store is cleared one entry per cycle, with in_ready low.
//   A finished result waits in the output register while the receiver
//   stalls, and the next request may already be taken.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_core
    import rws_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire in_item_t         in_data,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      out_item_t        out_data,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [CFG_W-1:0]  entries_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              res_valid;
    logic              res_ready;
    out_item_t         res_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [FIT_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [FIT_W-1:0]  mem_rdata;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ENTRIES_RESET;
        end
        else if (cfg_valid)
        begin
            entries_reg <= cfg_data;
        end
    end

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_data_reg <= res_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    rws_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .entries_in_use (entries_reg),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_data       (res_data),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .alu_req        (alu_req),
        .alu_rsp        (alu_rsp)
    );

    rws_fitness_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (FIT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    rws_addsub u_addsub (
        .req (alu_req),
        .rsp (alu_rsp)
    );

endmodule
`default_nettype wire

// ===== design/rws_fitness_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fitness store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module rws_fitness_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== design/rws_addsub.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared add/subtract unit
// One adder used for summing fitness, the restoring division steps and the
// walk over the running target.
// ----------------------------------------------------------------------------
module rws_addsub
    import rws_pkg::*;
(
    input  wire alu_req_t req,
    output      alu_rsp_t rsp
);

    logic [ALU_W-1:0] b_operand;
    logic [ALU_W:0]   full_sum;

    // Subtraction is a plus the inverted b plus one.
    always_comb
    begin
        b_operand = req.sub ? ~req.b : req.b;
        full_sum  = {1'b0, req.a} + {1'b0, b_operand} + {{ALU_W{1'b0}}, req.sub};
        rsp.carry = full_sum[ALU_W];
        rsp.sum   = full_sum[ALU_W-1:0];
    end

endmodule
`default_nettype wire

// ===== design/rws_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roulette wheel sequencer
// Clears the store after reset, executes writes, and runs the sum, zero-total
// check, divide and walk phases of a select on the shared add/subtract unit.
// ----------------------------------------------------------------------------
module rws_ctrl
    import rws_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output      logic                             in_ready,
    input  wire in_item_t                         in_data,
    input  wire logic [CFG_W-1:0]                 entries_in_use,
    output      logic                             res_valid,
    input  wire logic                             res_ready,
    output      out_item_t                        res_data,
    output      logic                             mem_we,
    output      logic [$clog2(TABLE_DEPTH)-1:0]   mem_waddr,
    output      logic [FIT_W-1:0]                 mem_wdata,
    output      logic [$clog2(TABLE_DEPTH)-1:0]   mem_raddr,
    input  wire logic [FIT_W-1:0]                 mem_rdata,
    output      alu_req_t                         alu_req,
    input  wire alu_rsp_t                         alu_rsp
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t             state_reg,    state_next;
    logic [CNT_W-1:0]   cnt_reg,      cnt_next;
    logic               pend_reg,     pend_next;
    logic [ADDR_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [TOTAL_W-1:0] total_reg,    total_next;
    logic [ALU_W-1:0]   rem_reg,      rem_next;
    logic [RND_W-1:0]   dvd_reg,      dvd_next;
    logic [STEP_W-1:0]  step_reg,     step_next;
    out_item_t          res_reg,      res_next;

    logic [CNT_W-1:0]   used_n;
    logic               in_range;
    logic               issue_rd;
    logic [ALU_W-1:0]   div_shifted;

    // Entries in use, saturated at the table depth
    always_comb
    begin
        if (32'(entries_in_use) > 32'(TABLE_DEPTH))
        begin
            used_n = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            used_n = CNT_W'(entries_in_use);
        end
    end

    assign in_range    = ({24'd0, in_data.entry_index} < 32'(TABLE_DEPTH));
    assign issue_rd    = (cnt_reg < used_n);
    assign div_shifted = {rem_reg[TOTAL_W-1:0], dvd_reg[RND_W-1]};

    // Next-state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        total_next    = total_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        step_next     = step_reg;
        res_next      = res_reg;

        mem_we    = 1'b0;
        mem_waddr = cnt_reg[ADDR_W-1:0];
        mem_wdata = '0;
        mem_raddr = cnt_reg[ADDR_W-1:0];

        alu_req.sub = 1'b0;
        alu_req.a   = {1'b0, total_reg};
        alu_req.b   = {{(ALU_W-FIT_W){1'b0}}, mem_rdata};

        case (state_reg)
            // Zero the store one entry per cycle after reset.
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TABLE_DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.req_type == REQ_WRITE)
                    begin
                        mem_we     = in_range;
                        mem_waddr  = ADDR_W'(in_data.entry_index);
                        mem_wdata  = in_data.fitness_value;
                        res_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        total_next = '0;
                        dvd_next   = in_data.random_word;
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SUM;
                    end
                end
            end

            // Stream the entries in use through the adder, one per cycle.
            ST_SUM:
            begin
                pend_next = issue_rd;
                if (issue_rd)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    total_next = alu_rsp.sum[TOTAL_W-1:0];
                end
                if (!issue_rd && !pend_reg)
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (total_reg == '0)
                begin
                    res_next.selected_index = '0;
                    res_next.status         = STATUS_ZERO_TOTAL;
                    res_next.fitness_sum    = '0;
                    state_next              = ST_FINISH;
                end
                else
                begin
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end

            // Restoring division: one quotient bit per cycle, remainder kept.
            ST_DIV:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = div_shifted;
                alu_req.b   = {1'b0, total_reg};
                rem_next    = alu_rsp.carry ? alu_rsp.sum : div_shifted;
                dvd_next    = {dvd_reg[RND_W-2:0], 1'b0};
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_WALK;
                end
            end

            // Walk the entries, taking each fitness off the remaining target.
            // The first entry larger than what remains is the one selected.
            ST_WALK:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = rem_reg;
                pend_next   = issue_rd;
                if (issue_rd)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (!alu_rsp.carry)
                    begin
                        res_next.selected_index = SEL_W'(pend_idx_reg);
                        res_next.status         = STATUS_OK;
                        res_next.fitness_sum    = total_reg;
                        state_next              = ST_FINISH;
                    end
                    else
                    begin
                        rem_next = alu_rsp.sum;
                    end
                end
                else if (!issue_rd)
                begin
                    res_next.selected_index = '0;
                    res_next.status         = STATUS_RAN_OFF;
                    res_next.fitness_sum    = total_reg;
                    state_next              = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Track the index of the entry whose data arrives next cycle.
        if (issue_rd)
        begin
            pend_idx_next = cnt_reg[ADDR_W-1:0];
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            total_reg    <= '0;
            rem_reg      <= '0;
            dvd_reg      <= '0;
            step_reg     <= '0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            total_reg    <= total_next;
            rem_reg      <= rem_next;
            dvd_reg      <= dvd_next;
            step_reg     <= step_next;
            res_reg      <= res_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH);
    assign res_data  = res_reg;

endmodule
`default_nettype wire

// ===== design/rws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roulette wheel selector port checker
// Watches the top-level ports and flags results or handshakes that break
// the block's contract.
// ----------------------------------------------------------------------------
module rws_checker
    import rws_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One request at a time: the block is busy after each transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // A zero total reports no index and no total.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_ZERO_TOTAL)
        |-> (out_data.fitness_sum == '0) && (out_data.selected_index == '0))
        else $error("zero-total result carries data");

    // A walk off the end reports index zero with a non-zero total.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_RAN_OFF)
        |-> (out_data.selected_index == '0) && (out_data.fitness_sum != '0))
        else $error("ran-off result malformed");

    // Only defined status codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == STATUS_OK)
                   || (out_data.status == STATUS_ZERO_TOTAL)
                   || (out_data.status == STATUS_RAN_OFF))
        else $error("undefined status code");

endmodule

bind roulette_wheel_selector_core rws_checker u_rws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
